// ===== rtl/oid_pkg.sv =====
// Shared types and codes for the ordered id/offset table.
// Holds the operation and status codes, the controller states and the
// command and status structs between controller and datapath. No dependencies.
`default_nettype none

package oid_pkg;

	// Operation codes carried by func.
	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_SEARCH = 2'd1;
	localparam logic [1:0] OP_DELETE = 2'd2;

	// Result status codes.
	localparam logic [1:0] ST_DONE      = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;

	// Field widths fixed by the interface.
	localparam int KEY_W    = 32;
	localparam int OFFSET_W = 31;
	localparam int TOTAL_W  = 5;

	// Controller states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_SCAN,
		S_SHIFT,
		S_FINISH
	} state_t;

	// Read address selection for the table memory.
	typedef enum logic [1:0] {
		RD_ZERO,
		RD_IDX1,
		RD_IDX2
	} rd_sel_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic    load_item;
		logic    ins_write;
		logic    shift_write;
		rd_sel_t rd_sel;
		logic    idx_clr;
		logic    idx_inc;
		logic    count_dec;
		logic    set_done;
		logic    set_full;
		logic    take_found;
		logic    out_load;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [1:0] func;
		logic       count_zero;
		logic       count_full;
		logic       match;
		logic       last;
		logic       out_free;
	} sts_t;

endpackage

`default_nettype wire

// ===== rtl/oid_dp.sv =====
// Datapath of the ordered id/offset table: entry memory, count, scan index,
// latched transaction and the result register.
// Depends on oid_pkg.
`default_nettype none

module oid_dp #(
	parameter int TABLE_DEPTH = 16
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire oid_pkg::cmd_t                       cmd,
	output oid_pkg::sts_t                            sts,
	input  wire logic [1:0]                          func,
	input  wire logic signed [oid_pkg::KEY_W-1:0]    key,
	input  wire logic [oid_pkg::OFFSET_W-1:0]        offset_value,
	output logic                                     rsp_valid,
	input  wire logic                                rsp_stall,
	output logic [1:0]                               status,
	output logic [oid_pkg::OFFSET_W-1:0]             found_offset,
	output logic [oid_pkg::TOTAL_W-1:0]              entry_total
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int DW = oid_pkg::KEY_W + oid_pkg::OFFSET_W;

	// Entry memory, one id and offset per word, oldest entry at address zero.
	logic [DW-1:0] entry_mem [TABLE_DEPTH];
	logic [DW-1:0] rd_data_q;

	logic [1:0]                    func_q;
	logic [oid_pkg::KEY_W-1:0]     key_q;
	logic [oid_pkg::OFFSET_W-1:0]  ofs_q;
	logic [CW-1:0]                 count_q;
	logic [CW-1:0]                 idx_q;
	logic [1:0]                    status_q;
	logic [oid_pkg::OFFSET_W-1:0]  found_q;
	logic                          rsp_valid_q;
	logic [1:0]                    rsp_status_q;
	logic [oid_pkg::OFFSET_W-1:0]  rsp_found_q;
	logic [oid_pkg::TOTAL_W-1:0]   rsp_total_q;

	logic [CW:0]   idx_plus1;
	logic [CW-1:0] rd_idx;
	logic [AW-1:0] rd_addr;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [DW-1:0] wr_data;

	assign idx_plus1 = {1'b0, idx_q} + (CW+1)'(1);

	// Read address selection.
	always_comb begin
		case (cmd.rd_sel)
			oid_pkg::RD_ZERO: rd_idx = '0;
			oid_pkg::RD_IDX1: rd_idx = idx_q + CW'(1);
			oid_pkg::RD_IDX2: rd_idx = idx_q + CW'(2);
			default:          rd_idx = '0;
		endcase
	end
	assign rd_addr = rd_idx[AW-1:0];

	// Write port: append on insert, move one entry down on delete.
	always_comb begin
		wr_en   = cmd.ins_write | cmd.shift_write;
		wr_addr = cmd.ins_write ? count_q[AW-1:0] : idx_q[AW-1:0];
		wr_data = cmd.ins_write ? {key_q, ofs_q} : rd_data_q;
	end

	// Memory access, read data registered.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_mem[wr_addr] <= wr_data;
		end
		rd_data_q <= entry_mem[rd_addr];
	end

	// Latched transaction.
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			func_q <= func;
			key_q  <= key;
			ofs_q  <= offset_value;
		end
	end

	// Entry count and scan index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			idx_q   <= '0;
		end else begin
			if (cmd.ins_write) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.count_dec) begin
				count_q <= count_q - CW'(1);
			end
			if (cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_plus1[CW-1:0];
			end
		end
	end

	// Working result of the current transaction.
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			status_q <= oid_pkg::ST_NOT_FOUND;
			found_q  <= '0;
		end else begin
			if (cmd.set_done) begin
				status_q <= oid_pkg::ST_DONE;
			end else if (cmd.set_full) begin
				status_q <= oid_pkg::ST_FULL;
			end
			if (cmd.take_found) begin
				found_q <= rd_data_q[oid_pkg::OFFSET_W-1:0];
			end
		end
	end

	// Output register, loaded only when empty or being taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else begin
			rsp_valid_q <= cmd.out_load | (rsp_valid_q & rsp_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			rsp_status_q <= status_q;
			rsp_found_q  <= found_q;
			rsp_total_q  <= oid_pkg::TOTAL_W'(count_q);
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign status       = rsp_status_q;
	assign found_offset = rsp_found_q;
	assign entry_total  = rsp_total_q;

	// Status toward the controller.
	always_comb begin
		sts.func       = func_q;
		sts.count_zero = (count_q == '0);
		sts.count_full = ({1'b0, count_q} >= (CW+1)'(TABLE_DEPTH));
		sts.match      = (rd_data_q[DW-1:oid_pkg::OFFSET_W] == key_q);
		sts.last       = (idx_plus1 >= {1'b0, count_q});
		sts.out_free   = ~rsp_valid_q | ~rsp_stall;
	end

endmodule

`default_nettype wire

// ===== rtl/oid_ctrl.sv =====
// Controller of the ordered id/offset table: sequences insert, the oldest-first
// scan, the shift that closes a gap on delete, and the hand-off of the result.
// Depends on oid_pkg.
`default_nettype none

module oid_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire oid_pkg::sts_t sts,
	output oid_pkg::cmd_t      cmd
);

	oid_pkg::state_t state_q;
	oid_pkg::state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= oid_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		cmd.rd_sel = oid_pkg::RD_ZERO;
		req_stall  = 1'b1;
		unique case (state_q)
			oid_pkg::S_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					cmd.load_item = 1'b1;
					state_d       = oid_pkg::S_DECODE;
				end
			end
			oid_pkg::S_DECODE: begin
				state_d = oid_pkg::S_FINISH;
				unique case (sts.func) inside
					oid_pkg::OP_INSERT: begin
						if (sts.count_full) begin
							cmd.set_full = 1'b1;
						end else begin
							cmd.ins_write = 1'b1;
							cmd.set_done  = 1'b1;
						end
					end
					oid_pkg::OP_SEARCH, oid_pkg::OP_DELETE: begin
						if (!sts.count_zero) begin
							cmd.rd_sel  = oid_pkg::RD_ZERO;
							cmd.idx_clr = 1'b1;
							state_d     = oid_pkg::S_SCAN;
						end
					end
					default: begin
						state_d = oid_pkg::S_FINISH;
					end
				endcase
			end
			oid_pkg::S_SCAN: begin
				// Compare the entry at the index while the next one is read.
				cmd.rd_sel = oid_pkg::RD_IDX1;
				if (sts.match) begin
					if (sts.func == oid_pkg::OP_SEARCH) begin
						cmd.take_found = 1'b1;
						cmd.set_done   = 1'b1;
						state_d        = oid_pkg::S_FINISH;
					end else begin
						state_d = oid_pkg::S_SHIFT;
					end
				end else if (sts.last) begin
					state_d = oid_pkg::S_FINISH;
				end else begin
					cmd.idx_inc = 1'b1;
				end
			end
			oid_pkg::S_SHIFT: begin
				// Move each younger entry down one place.
				cmd.rd_sel = oid_pkg::RD_IDX2;
				if (sts.last) begin
					cmd.count_dec = 1'b1;
					cmd.set_done  = 1'b1;
					state_d       = oid_pkg::S_FINISH;
				end else begin
					cmd.shift_write = 1'b1;
					cmd.idx_inc     = 1'b1;
				end
			end
			oid_pkg::S_FINISH: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = oid_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = oid_pkg::S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/ordered_id_offset_table.sv =====
// Ordered id/offset table: keeps up to TABLE_DEPTH (id, offset) pairs in
// insertion order. Each request transaction carries func (insert, search,
// delete), key and offset_value; each yields one response transaction with
// status, found_offset and entry_total.
// Both channels use valid/stall; a transaction moves on a clock edge with
// valid high and stall low. req_stall is low only while the block is idle.
// Steps: an insert, or an operation on an empty table, goes from the decode
// state to the finish state, which loads the response register. Search and
// delete scan the table oldest first, one entry per cycle through the single
// read port of the entry memory; a search stops at a match, a delete then
// moves each younger entry down one place at the same rate, and a miss ends
// after the last entry. Each outcome is loaded from the finish state, and
// the next request is accepted in the idle state that follows the hand-off.
// The response waits in an output register; the next request is accepted
// while it is still stalled, and the block holds its finished result until
// the output register frees up.
// Reset empties the table at once (count cleared); entry contents need no
// clearing pass.
// Depends on oid_pkg, oid_ctrl and oid_dp.
`default_nettype none

module ordered_id_offset_table #(
	parameter int TABLE_DEPTH = 16
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              req_valid,
	output logic                                   req_stall,
	input  wire logic [1:0]                        func,
	input  wire logic signed [oid_pkg::KEY_W-1:0]  key,
	input  wire logic [oid_pkg::OFFSET_W-1:0]      offset_value,
	output logic                                   rsp_valid,
	input  wire logic                              rsp_stall,
	output logic [1:0]                             status,
	output logic [oid_pkg::OFFSET_W-1:0]           found_offset,
	output logic [oid_pkg::TOTAL_W-1:0]            entry_total
);

	oid_pkg::cmd_t cmd;
	oid_pkg::sts_t sts;

	oid_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	oid_dp #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.func         (func),
		.key          (key),
		.offset_value (offset_value),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.status       (status),
		.found_offset (found_offset),
		.entry_total  (entry_total)
	);

endmodule

`default_nettype wire
